// ===== rtl/stopwatch_with_debounced_buttons_core_macros.svh =====
// Assertion macros for the stopwatch core checker.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef STOPWATCH_WITH_DEBOUNCED_BUTTONS_CORE_MACROS_SVH
`define STOPWATCH_WITH_DEBOUNCED_BUTTONS_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SWDB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("swdb assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SWDB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("swdb assertion failed");

`endif

// ===== rtl/swdb_pkg.sv =====
// Shared types and constants for the debounced-button stopwatch core.
// No dependencies.
`timescale 1ns / 1ps

package swdb_pkg;

    localparam int TIMER_WIDTH = 16;
    localparam int CMP_W       = ((TIMER_WIDTH > 16) ? TIMER_WIDTH : 16) + 1;

    localparam logic [7:0] CFG_TICK_DIVIDE    = 8'd0;
    localparam logic [7:0] CFG_DEBOUNCE_FALL  = 8'd1;
    localparam logic [7:0] CFG_DEBOUNCE_RISE  = 8'd2;
    localparam logic [7:0] CFG_REFRESH_PERIOD = 8'd3;
    localparam logic [7:0] CFG_POINT_MASK     = 8'd4;
    localparam logic [7:0] CFG_RUN_ENABLE     = 8'd5;

    localparam logic [15:0] RST_TICK_DIVIDE    = 16'd100;
    localparam logic [15:0] RST_DEBOUNCE_FALL  = 16'd30;
    localparam logic [15:0] RST_DEBOUNCE_RISE  = 16'd30;
    localparam logic [7:0]  RST_REFRESH_PERIOD = 8'd5;
    localparam logic [3:0]  RST_POINT_MASK     = 4'b1010;
    localparam logic        RST_RUN_ENABLE     = 1'b1;

    localparam logic [3:0] BLANK_DIGIT = 4'd8;
    localparam int RESULT_W = 24;

    typedef struct packed {
        logic [3:0] minutes;
        logic [3:0] tens;
        logic [3:0] seconds;
        logic [3:0] tenths;
    } t_digits;

    localparam t_digits BLANK_DIGITS = '{BLANK_DIGIT, BLANK_DIGIT, BLANK_DIGIT, BLANK_DIGIT};

    typedef struct packed {
        logic [15:0] fall_ticks;
        logic [15:0] rise_ticks;
    } t_db_cfg;

    typedef struct packed {
        logic step;
        logic run;
        logic clear;
    } t_cnt_ctl;

    // Packed so that the last field lands in the lowest bits.
    typedef struct packed {
        logic       pad;
        logic       count_visible;
        logic       limit_reached;
        logic       refresh_strobe;
        logic [3:0] points_out;
        t_digits    shown;
    } t_result;

endpackage

// ===== rtl/stopwatch_with_debounced_buttons_core.sv =====
// Channel   Dir  Handshake                     Payload
// s_axis    in   i_s_tvalid / o_s_tready       one 1 ms tick with two button levels
// m_axis    out  o_m_tvalid / i_m_tready       display digits and status per tick
// cfg       in   i_cfg_valid / o_cfg_ready     register index and write data
//
// One tick item is taken per cycle while the queue has room; its result is registered into the output queue.
// A two-entry output queue lets a tick be taken while one result waits downstream.
// Input stalls only when both queue entries are full; cfg writes are always ready.
// Synchronous active-low reset; no clearing pass.
// Depends on swdb_pkg, swdb_debounce, swdb_count, swdb_outq.
`timescale 1ns / 1ps

module stopwatch_with_debounced_buttons_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [0] show_button_level, [1] clear_button_level
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [3:0] shown_tenths, [7:4] shown_seconds, [11:8] shown_tens, [15:12] shown_minutes,
    // [19:16] points_out, [20] refresh_strobe, [21] limit_reached, [22] count_visible
    output logic [23:0] o_m_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic [15:0] r_tick_divide;
    logic [15:0] r_fall_ticks;
    logic [15:0] r_rise_ticks;
    logic [7:0]  r_refresh_period;
    logic [3:0]  r_point_mask;
    logic        r_run_enable;

    logic              r_visible,  n_visible;
    swdb_pkg::t_digits r_display,  n_display;
    logic [7:0]        r_refresh,  n_refresh;
    logic              strobe;
    logic [8:0]        refresh_inc;

    logic              accept;
    logic              show_press;
    logic              clear_press;
    swdb_pkg::t_db_cfg db_cfg;
    swdb_pkg::t_cnt_ctl cnt_ctl;
    swdb_pkg::t_digits next_digits;
    logic              next_sat;
    swdb_pkg::t_result result;
    logic              q_ready;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = q_ready;
    assign accept      = i_s_tvalid && q_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_divide    <= swdb_pkg::RST_TICK_DIVIDE;
            r_fall_ticks     <= swdb_pkg::RST_DEBOUNCE_FALL;
            r_rise_ticks     <= swdb_pkg::RST_DEBOUNCE_RISE;
            r_refresh_period <= swdb_pkg::RST_REFRESH_PERIOD;
            r_point_mask     <= swdb_pkg::RST_POINT_MASK;
            r_run_enable     <= swdb_pkg::RST_RUN_ENABLE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                swdb_pkg::CFG_TICK_DIVIDE:    r_tick_divide    <= i_cfg_data;
                swdb_pkg::CFG_DEBOUNCE_FALL:  r_fall_ticks     <= i_cfg_data;
                swdb_pkg::CFG_DEBOUNCE_RISE:  r_rise_ticks     <= i_cfg_data;
                swdb_pkg::CFG_REFRESH_PERIOD: r_refresh_period <= i_cfg_data[7:0];
                swdb_pkg::CFG_POINT_MASK:     r_point_mask     <= i_cfg_data[3:0];
                swdb_pkg::CFG_RUN_ENABLE:     r_run_enable     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign db_cfg = '{fall_ticks: r_fall_ticks, rise_ticks: r_rise_ticks};

    swdb_debounce u_db_show (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (accept),
        .i_level (i_s_tdata[0]),
        .i_cfg   (db_cfg),
        .o_press (show_press)
    );

    swdb_debounce u_db_clear (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (accept),
        .i_level (i_s_tdata[1]),
        .i_cfg   (db_cfg),
        .o_press (clear_press)
    );

    assign cnt_ctl = '{step: accept, run: r_run_enable, clear: clear_press};

    swdb_count u_count (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (cnt_ctl),
        .i_tick_divide (r_tick_divide),
        .o_next_digits (next_digits),
        .o_next_sat    (next_sat)
    );

    // show press first, clear press second
    always_comb begin
        n_visible = r_visible;
        if (show_press)  n_visible = 1'b1;
        if (clear_press) n_visible = 1'b0;
        n_display   = clear_press ? swdb_pkg::BLANK_DIGITS : r_display;
        refresh_inc = {1'b0, r_refresh} + 9'd1;
        strobe      = 1'b0;
        if (refresh_inc >= {1'b0, r_refresh_period}) begin
            n_refresh = '0;
            strobe    = 1'b1;
            n_display = n_visible ? next_digits : swdb_pkg::BLANK_DIGITS;
        end else begin
            n_refresh = refresh_inc[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_visible <= 1'b0;
            r_display <= swdb_pkg::BLANK_DIGITS;
            r_refresh <= '0;
        end else if (accept) begin
            r_visible <= n_visible;
            r_display <= n_display;
            r_refresh <= n_refresh;
        end
    end

    always_comb begin
        result.pad            = 1'b0;
        result.count_visible  = n_visible;
        result.limit_reached  = next_sat;
        result.refresh_strobe = strobe;
        result.points_out     = r_point_mask;
        result.shown          = n_display;
    end

    swdb_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (accept),
        .i_data     (result),
        .o_ready    (q_ready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

// ===== rtl/swdb_debounce.sv =====
// Four-state button debouncer with a saturating elapsed-tick timer.
// Depends on swdb_pkg.
`timescale 1ns / 1ps

module swdb_debounce (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic             i_level,
    input  swdb_pkg::t_db_cfg i_cfg,
    output logic             o_press
);

    typedef enum logic [1:0] {
        DB_IDLE    = 2'd0,
        DB_FALLING = 2'd1,
        DB_LOW     = 2'd2,
        DB_RELEASE = 2'd3
    } t_db_state;

    localparam logic [swdb_pkg::TIMER_WIDTH-1:0] TIMER_MAX = '1;

    t_db_state                          r_state, n_state;
    logic [swdb_pkg::TIMER_WIDTH-1:0]   r_timer, n_timer;
    logic [swdb_pkg::CMP_W-1:0]         elapsed;
    logic [swdb_pkg::CMP_W-1:0]         limit;
    logic                               wait_done;
    logic                               at_max;

    always_comb begin
        elapsed   = swdb_pkg::CMP_W'(r_timer) + swdb_pkg::CMP_W'(1);
        limit     = (r_state == DB_FALLING) ? swdb_pkg::CMP_W'(i_cfg.fall_ticks)
                                            : swdb_pkg::CMP_W'(i_cfg.rise_ticks);
        at_max    = elapsed > swdb_pkg::CMP_W'(TIMER_MAX);
        wait_done = (elapsed > limit) || at_max;
    end

    always_comb begin
        n_state = r_state;
        n_timer = r_timer;
        o_press = 1'b0;
        case (r_state)
            DB_IDLE: begin
                if (!i_level) begin
                    n_timer = '0;
                    n_state = DB_FALLING;
                    o_press = 1'b1;
                end
            end
            DB_FALLING: begin
                n_timer = at_max ? TIMER_MAX : elapsed[swdb_pkg::TIMER_WIDTH-1:0];
                if (wait_done) n_state = DB_LOW;
            end
            DB_LOW: begin
                if (i_level) begin
                    n_timer = '0;
                    n_state = DB_RELEASE;
                end
            end
            DB_RELEASE: begin
                n_timer = at_max ? TIMER_MAX : elapsed[swdb_pkg::TIMER_WIDTH-1:0];
                if (wait_done) n_state = DB_IDLE;
            end
            default: begin
                n_state = DB_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DB_IDLE;
            r_timer <= '0;
        end else if (i_step) begin
            r_state <= n_state;
            r_timer <= n_timer;
        end
    end

endmodule

// ===== rtl/swdb_count.sv =====
// Tick prescaler and saturating four-digit BCD stopwatch count.
// Depends on swdb_pkg.
`timescale 1ns / 1ps

module swdb_count (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  swdb_pkg::t_cnt_ctl i_ctl,
    input  logic [15:0]        i_tick_divide,
    output swdb_pkg::t_digits  o_next_digits,
    output logic               o_next_sat
);

    logic [15:0]       r_prescale, n_prescale;
    swdb_pkg::t_digits r_digits,   n_digits;
    logic              r_sat,      n_sat;
    logic [16:0]       pre_inc;

    always_comb begin
        n_prescale = r_prescale;
        n_digits   = r_digits;
        n_sat      = r_sat;
        pre_inc    = {1'b0, r_prescale} + 17'd1;
        if (i_ctl.run) begin
            if (pre_inc >= {1'b0, i_tick_divide}) begin
                n_prescale = '0;
                n_sat      = 1'b0;
                if (r_digits.tenths != 4'd9) begin
                    n_digits.tenths = r_digits.tenths + 4'd1;
                end else if (r_digits.seconds != 4'd9) begin
                    n_digits.tenths  = 4'd0;
                    n_digits.seconds = r_digits.seconds + 4'd1;
                end else if (r_digits.tens != 4'd5) begin
                    n_digits.tenths  = 4'd0;
                    n_digits.seconds = 4'd0;
                    n_digits.tens    = r_digits.tens + 4'd1;
                end else if (r_digits.minutes != 4'd9) begin
                    n_digits.tenths  = 4'd0;
                    n_digits.seconds = 4'd0;
                    n_digits.tens    = 4'd0;
                    n_digits.minutes = r_digits.minutes + 4'd1;
                end else begin
                    n_digits = '{4'd9, 4'd5, 4'd9, 4'd9};
                    n_sat    = 1'b1;
                end
            end else begin
                n_prescale = pre_inc[15:0];
            end
        end
        if (i_ctl.clear) begin
            n_digits = '0;
            n_sat    = 1'b0;
        end
    end

    assign o_next_digits = n_digits;
    assign o_next_sat    = n_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prescale <= '0;
            r_digits   <= '0;
            r_sat      <= 1'b0;
        end else if (i_ctl.step) begin
            r_prescale <= n_prescale;
            r_digits   <= n_digits;
            r_sat      <= n_sat;
        end
    end

endmodule

// ===== rtl/swdb_outq.sv =====
// Two-entry result queue between the tick logic and the output stream.
// Depends on swdb_pkg.
`timescale 1ns / 1ps

module swdb_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  swdb_pkg::t_result i_data,
    output logic              o_ready,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [swdb_pkg::RESULT_W-1:0] o_m_tdata
);

    swdb_pkg::t_result r_buf [2];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_count;
    logic              pop;

    assign o_ready    = (r_count != 2'd2);
    assign o_m_tvalid = (r_count != 2'd0);
    assign o_m_tdata  = r_buf[r_rd_ptr];
    assign pop        = o_m_tvalid && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (i_push) r_buf[r_wr_ptr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= ~r_wr_ptr;
            if (pop)    r_rd_ptr <= ~r_rd_ptr;
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/swdb_checker.sv =====
// Port-level checker for the stopwatch core, bound to the top level.
// Depends on stopwatch_with_debounced_buttons_core_macros.svh.
`timescale 1ns / 1ps
`include "stopwatch_with_debounced_buttons_core_macros.svh"

module swdb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata
);

    logic shown_ok;
    logic refresh_hidden;
    logic refresh_visible;
    logic refresh_limit;

    assign refresh_hidden  = o_m_tvalid && o_m_tdata[20] && !o_m_tdata[22];
    assign refresh_visible = o_m_tvalid && o_m_tdata[20] && o_m_tdata[22];
    assign refresh_limit   = refresh_visible && o_m_tdata[21];
    assign shown_ok = (o_m_tdata[3:0] <= 4'd9) && (o_m_tdata[7:4] <= 4'd9)
                   && (o_m_tdata[11:8] <= 4'd5) && (o_m_tdata[15:12] <= 4'd9);

    `SWDB_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid)
    `SWDB_ASSERT_NOW(a_stall_means_pending, !o_s_tready, o_m_tvalid)
    `SWDB_ASSERT_NOW(a_hidden_blank, refresh_hidden, o_m_tdata[15:0] == 16'h8888)
    `SWDB_ASSERT_NOW(a_visible_bcd, refresh_visible, shown_ok)
    `SWDB_ASSERT_NOW(a_limit_value, refresh_limit, o_m_tdata[15:0] == 16'h9599)

endmodule

bind stopwatch_with_debounced_buttons_core swdb_checker u_swdb_checker (.*);

// ===== sim/stopwatch_with_debounced_buttons_core_test.sv =====
// Self-checking bench for stopwatch_with_debounced_buttons_core: drives button ticks
// and register writes, predicts every display frame and checks it field by field.
// Depends on swdb_pkg and the core RTL.
`timescale 1ns / 1ps

module stopwatch_with_debounced_buttons_core_test;

    localparam int          STALL_LIMIT   = 2000;
    localparam int          IDLE_PCT      = 37;
    localparam int unsigned TMR_MAX       = (1 << swdb_pkg::TIMER_WIDTH) - 1;
    localparam logic [7:0]  CFG_NONE_NEXT = swdb_pkg::CFG_RUN_ENABLE + 8'd1;
    localparam logic [7:0]  CFG_NONE_LAST = 8'hFF;

    typedef enum logic [1:0] {BTN_UP, BTN_FALLING, BTN_DOWN, BTN_RISING} t_btn_state;

    typedef struct packed {
        logic [15:0] divide;
        logic [15:0] fall;
        logic [15:0] rise;
        logic [7:0]  period;
        logic [3:0]  points;
        logic        run;
    } t_settings;

    // bit 0 show level, bit 1 clear level; 0 is pressed
    localparam logic [1:0] PLAN_RESET [6] = '{2'b11, 2'b10, 2'b11, 2'b11, 2'b01, 2'b11};
    localparam logic [1:0] PLAN_EDGE [20] = '{
        2'b11, 2'b11, 2'b10, 2'b10, 2'b11, 2'b11, 2'b10, 2'b11, 2'b01, 2'b11,
        2'b11, 2'b11, 2'b00, 2'b11, 2'b11, 2'b11, 2'b10, 2'b11, 2'b11, 2'b11};

    localparam t_settings S_EDGE = '{16'd0, 16'd0, 16'd0, 8'd0, 4'hF, 1'b1};
    localparam t_settings S_FAST = '{16'd1, 16'd2, 16'd3, 8'd1, 4'h0, 1'b1};
    localparam t_settings S_MID  = '{16'd3, 16'd5, 16'd1, 8'd3, 4'h5, 1'b1};
    localparam t_settings S_SLOW = '{16'd7, 16'd1, 16'd4, 8'd255, 4'hA, 1'b1};
    localparam t_settings S_HALT = '{16'd2, 16'd2, 16'd2, 8'd2, 4'h3, 1'b0};

    class stopwatch_shadow;
        logic [15:0] divide, fall, rise;
        logic [7:0]  period;
        logic [3:0]  points;
        logic        run;
        int unsigned prescale;
        swdb_pkg::t_digits count, shown;
        logic        at_limit, visible;
        t_btn_state  btn [2];
        int unsigned btn_timer [2];
        int unsigned refresh_timer;
        swdb_pkg::t_result due [$];
        int          errors, ticks, frames, writes;

        function new();
            divide   = swdb_pkg::RST_TICK_DIVIDE;
            fall     = swdb_pkg::RST_DEBOUNCE_FALL;
            rise     = swdb_pkg::RST_DEBOUNCE_RISE;
            period   = swdb_pkg::RST_REFRESH_PERIOD;
            points   = swdb_pkg::RST_POINT_MASK;
            run      = swdb_pkg::RST_RUN_ENABLE;
            prescale = 0;
            count    = '0;
            shown    = swdb_pkg::BLANK_DIGITS;
            at_limit = 1'b0;
            visible  = 1'b0;
            foreach (btn[k]) begin
                btn[k]       = BTN_UP;
                btn_timer[k] = 0;
            end
            refresh_timer = 0;
            errors = 0;
            ticks  = 0;
            frames = 0;
            writes = 0;
        endfunction

        function void configure(logic [7:0] idx, logic [15:0] data);
            writes++;
            case (idx)
                swdb_pkg::CFG_TICK_DIVIDE:    divide = data;
                swdb_pkg::CFG_DEBOUNCE_FALL:  fall   = data;
                swdb_pkg::CFG_DEBOUNCE_RISE:  rise   = data;
                swdb_pkg::CFG_REFRESH_PERIOD: period = data[7:0];
                swdb_pkg::CFG_POINT_MASK:     points = data[3:0];
                swdb_pkg::CFG_RUN_ENABLE:     run    = data[0];
                default: ;
            endcase
        endfunction

        function void advance();
            at_limit = 1'b0;
            if (count.tenths != 4'd9) begin
                count.tenths = count.tenths + 4'd1;
            end else begin
                count.tenths = 4'd0;
                if (count.seconds != 4'd9) begin
                    count.seconds = count.seconds + 4'd1;
                end else begin
                    count.seconds = 4'd0;
                    if (count.tens != 4'd5) begin
                        count.tens = count.tens + 4'd1;
                    end else begin
                        count.tens = 4'd0;
                        if (count.minutes != 4'd9) begin
                            count.minutes = count.minutes + 4'd1;
                        end else begin
                            // hold at 9:59.9
                            count.minutes = 4'd9;
                            count.tens    = 4'd5;
                            count.seconds = 4'd9;
                            count.tenths  = 4'd9;
                            at_limit      = 1'b1;
                        end
                    end
                end
            end
        endfunction

        // timer saturates; hitting the top also ends the wait
        function bit waited(int k, logic [15:0] limit);
            int unsigned e;
            bit over;
            e = btn_timer[k] + 1;
            over = (e > limit) || (e > TMR_MAX);
            btn_timer[k] = (e > TMR_MAX) ? TMR_MAX : e;
            return over;
        endfunction

        function bit press_seen(int k, logic level);
            bit hit;
            hit = 1'b0;
            case (btn[k])
                BTN_UP: begin
                    if (!level) begin
                        btn_timer[k] = 0;
                        btn[k] = BTN_FALLING;
                        hit = 1'b1;
                    end
                end
                BTN_FALLING: begin
                    if (waited(k, fall)) btn[k] = BTN_DOWN;
                end
                BTN_DOWN: begin
                    if (level) begin
                        btn_timer[k] = 0;
                        btn[k] = BTN_RISING;
                    end
                end
                default: begin
                    if (waited(k, rise)) btn[k] = BTN_UP;
                end
            endcase
            return hit;
        endfunction

        function void note_tick(logic [1:0] levels);
            swdb_pkg::t_result r;
            int unsigned step;
            bit          strobe;
            ticks++;
            strobe = 1'b0;
            if (run) begin
                step = prescale + 1;
                if (step >= divide) begin
                    prescale = 0;
                    advance();
                end else begin
                    prescale = step;
                end
            end
            if (press_seen(0, levels[0])) visible = 1'b1;
            if (press_seen(1, levels[1])) begin
                count    = '0;
                shown    = swdb_pkg::BLANK_DIGITS;
                at_limit = 1'b0;
                visible  = 1'b0;
            end
            if (refresh_timer + 1 >= period) begin
                refresh_timer = 0;
                strobe = 1'b1;
                shown = visible ? count : swdb_pkg::BLANK_DIGITS;
            end else begin
                refresh_timer++;
            end
            r = '0;
            r.shown          = shown;
            r.points_out     = points;
            r.refresh_strobe = strobe;
            r.limit_reached  = at_limit;
            r.count_visible  = visible;
            due.push_back(r);
        endfunction

        task report(string what);
            errors++;
            $display("ERROR t=%0t: %s", $time, what);
        endtask

        task compare(string name, logic [3:0] got, logic [3:0] want);
            if (got !== want)
                report($sformatf("frame %0d %s: got %0h, expected %0h", frames, name, got, want));
        endtask

        task check_frame(logic [23:0] data);
            swdb_pkg::t_result got, want;
            got = data;
            frames++;
            if (due.size() == 0) begin
                report($sformatf("frame %0d arrived with no tick pending", frames));
                return;
            end
            want = due.pop_front();
            compare("tenths", got.shown.tenths, want.shown.tenths);
            compare("seconds", got.shown.seconds, want.shown.seconds);
            compare("tens", got.shown.tens, want.shown.tens);
            compare("minutes", got.shown.minutes, want.shown.minutes);
            compare("points", got.points_out, want.points_out);
            compare("strobe", got.refresh_strobe, want.refresh_strobe);
            compare("limit", got.limit_reached, want.limit_reached);
            compare("visible", got.count_visible, want.count_visible);
            compare("pad", got.pad, want.pad);
        endtask
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata   = '0;
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [23:0] o_m_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data  = '0;

    bit              steady       = 1'b0;
    int              stall_cycles = 0;
    stopwatch_shadow sw           = new();

    stopwatch_with_debounced_buttons_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) i_m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sw.check_frame(o_m_tdata);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("no handshake for %0d cycles at t=%0t", STALL_LIMIT, $time);
            $display("stopwatch_with_debounced_buttons_core: mismatch");
            $finish;
        end
    end

    task automatic send_tick(logic [1:0] levels);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {6'd0, levels};
        do @(posedge i_clk); while (!o_s_tready);
        sw.note_tick(levels);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (sw.due.size() != 0) @(posedge i_clk);
    endtask

    task automatic put_reg(logic [7:0] idx, logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sw.configure(idx, data);
    endtask

    // narrow registers get junk in their unused upper bits
    task automatic apply(t_settings s, bit stray);
        put_reg(swdb_pkg::CFG_TICK_DIVIDE, s.divide);
        put_reg(swdb_pkg::CFG_DEBOUNCE_FALL, s.fall);
        put_reg(swdb_pkg::CFG_DEBOUNCE_RISE, s.rise);
        put_reg(swdb_pkg::CFG_REFRESH_PERIOD, {8'($urandom), s.period});
        put_reg(swdb_pkg::CFG_POINT_MASK, {12'($urandom), s.points});
        put_reg(swdb_pkg::CFG_RUN_ENABLE, {15'($urandom), s.run});
        if (stray) begin
            put_reg(CFG_NONE_NEXT, 16'($urandom));
            put_reg(CFG_NONE_LAST, 16'($urandom));
        end
        i_cfg_valid <= 1'b0;
    endtask

    // held presses and releases with occasional one-tick bounces
    task automatic run_random(int n, int pause_at);
        logic [1:0] lv;
        int         hold [2];
        int         span;
        lv = 2'b11;
        span = ((sw.fall > sw.rise) ? sw.fall : sw.rise) + 8;
        hold[0] = $urandom_range(span, 1);
        hold[1] = $urandom_range(span * 10, 1);
        for (int i = 0; i < n; i++) begin
            for (int k = 0; k < 2; k++) begin
                if (hold[k] == 0) begin
                    lv[k] = ~lv[k];
                    // long clear releases let the count grow
                    hold[k] = $urandom_range(span * ((k == 1 && lv[k]) ? 10 : 1), 1);
                end
                hold[k]--;
            end
            if (i == pause_at) drain();
            send_tick(lv ^ (($urandom_range(99) < 8) ? 2'($urandom) : 2'b00));
        end
        drain();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (PLAN_RESET[i]) send_tick(PLAN_RESET[i]);
        drain();
        apply(S_EDGE, 1'b1);
        foreach (PLAN_EDGE[i]) send_tick(PLAN_EDGE[i]);
        drain();

        apply(S_FAST, 1'b0);
        run_random(150, -1);
        apply(S_MID, 1'b0);
        steady = 1'b1;
        run_random(200, 80);
        steady = 1'b0;
        apply(S_SLOW, 1'b0);
        run_random(300, 120);
        apply(S_HALT, 1'b0);
        run_random(100, -1);

        repeat (20) @(posedge i_clk);
        $display("checked %0d ticks, %0d frames, %0d register writes; %0d errors",
                 sw.ticks, sw.frames, sw.writes, sw.errors);
        $display("ran zero divide and refresh, bouncing buttons, frozen count, stray writes");
        if (sw.errors == 0 && sw.due.size() == 0) begin
            $display("stopwatch_with_debounced_buttons_core: match");
        end else begin
            $display("stopwatch_with_debounced_buttons_core: mismatch");
        end
        $finish;
    end

endmodule
